/* rtl/gouraud_box_band_shading_macros.svh */
// Assertion macros shared by the box shading RTL.
// Depends on nothing; every user names its clock "clock" and its reset "reset".
`ifndef GOURAUD_BOX_BAND_SHADING_MACROS_SVH
`define GOURAUD_BOX_BAND_SHADING_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define GBBS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next cycle.
`define GBBS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define GBBS_ASSERT(lbl, prop, msg)
`define GBBS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* rtl/gbbs_pkg.sv */
// Shared types, constants and defaults of the box band shading block.
// Depends on nothing; every other RTL file but the macro header imports it.
`timescale 1ns / 1ps
package gbbs_pkg;
   localparam int BOX_W_DEF     = 16;
   localparam int BOX_H_DEF     = 12;
   localparam int SCREEN_W_DEF  = 640;
   localparam int SCREEN_H_DEF  = 480;
   localparam int FRAC_BITS_DEF = 16;

   localparam int COORD_W    = 12;
   localparam int LIGHT_IN_W = 8;
   localparam int PIXEL_W    = 8;
   localparam int OUT_POS_W  = 10;
   localparam int SHADE_W    = 5;
   localparam int BAND_W     = PIXEL_W - SHADE_W;
   localparam int DIFF_W     = LIGHT_IN_W + 1;
   localparam int LIGHT_W    = 32;
   localparam int POS_W      = 14;
   localparam int DIVISOR_W  = 7;
   localparam int DIV_STEP   = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [SHADE_W-1:0] SHADE_MAX = 5'd31;

   typedef struct packed {
      logic                         op;
      logic signed [COORD_W-1:0]    box_x;
      logic signed [COORD_W-1:0]    box_y;
      logic signed [LIGHT_IN_W-1:0] light_top_left;
      logic signed [LIGHT_IN_W-1:0] light_top_right;
      logic signed [LIGHT_IN_W-1:0] light_bottom_left;
      logic signed [LIGHT_IN_W-1:0] light_bottom_right;
      logic                         skip_zero;
      logic [PIXEL_W-1:0]           src_pixel;
   } req_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0] screen_x;
      logic [OUT_POS_W-1:0] screen_y;
      logic [PIXEL_W-1:0]   color;
   } rsp_type;

   // Classified word as it waits between front and back.
   typedef struct packed {
      logic                      is_start;
      logic signed [COORD_W-1:0] box_x;
      logic signed [COORD_W-1:0] box_y;
      logic signed [DIFF_W-1:0]  light_tl;
      logic signed [DIFF_W-1:0]  diff_left;
      logic signed [DIFF_W-1:0]  diff_right;
      logic signed [DIFF_W-1:0]  diff_top;
      logic                      skip_zero;
      logic [PIXEL_W-1:0]        src_pixel;
   } entry_type;

   typedef struct packed {
      logic                      go;
      logic signed [LIGHT_W-1:0] dividend;
      logic [DIVISOR_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [LIGHT_W-1:0] quotient;
   } div_rsp_type;
endpackage

/* rtl/gbbs_front.sv */
// Front stage: accepts request words, classifies them and forms corner differences.
// Depends on gbbs_pkg.
`timescale 1ns / 1ps
module gbbs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  gbbs_pkg::req_type   req_word,
   output logic                push_valid,
   input  logic                push_ready,
   output gbbs_pkg::entry_type push_entry
);
   import gbbs_pkg::*;

   logic      front_valid_ff, front_valid_in;
   entry_type front_entry_ff, front_entry_in;
   logic      accept;

   assign req_stall = front_valid_ff & ~push_ready;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      front_entry_in.is_start   = (req_word.op == OP_START);
      front_entry_in.box_x      = req_word.box_x;
      front_entry_in.box_y      = req_word.box_y;
      front_entry_in.light_tl   = DIFF_W'(req_word.light_top_left);
      front_entry_in.diff_left  = DIFF_W'(req_word.light_bottom_left)
                                  - DIFF_W'(req_word.light_top_left);
      front_entry_in.diff_right = DIFF_W'(req_word.light_bottom_right)
                                  - DIFF_W'(req_word.light_top_right);
      front_entry_in.diff_top   = DIFF_W'(req_word.light_top_right)
                                  - DIFF_W'(req_word.light_top_left);
      front_entry_in.skip_zero  = req_word.skip_zero;
      front_entry_in.src_pixel  = req_word.src_pixel;
   end

   always_comb begin
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (accept) begin
         front_entry_ff <= front_entry_in;
      end
   end

   assign push_valid = front_valid_ff;
   assign push_entry = front_entry_ff;
endmodule

/* rtl/gbbs_queue.sv */
// Short queue of classified words between the front and back stages.
// Depends on gbbs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gouraud_box_band_shading_macros.svh"
module gbbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  gbbs_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop,
   output gbbs_pkg::entry_type pop_entry
);
   import gbbs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `GBBS_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
   `GBBS_ASSERT(a_ptr_track, PTR_W'(rd_ptr_ff + count_ff) == wr_ptr_ff, "queue pointers out of step")
endmodule

/* rtl/gbbs_div.sv */
// Iterative signed divider by a small positive divisor, DIV_STEP quotient bits per cycle.
// Quotient truncates toward zero. Depends on gbbs_pkg.
`timescale 1ns / 1ps
module gbbs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gbbs_pkg::div_req_type div_req,
   output gbbs_pkg::div_rsp_type div_rsp
);
   import gbbs_pkg::*;

   localparam int ITER  = LIGHT_W / DIV_STEP;
   localparam int CNT_W = $clog2(ITER + 1);

   logic                      busy_ff, busy_in;
   logic                      fin_ff, fin_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      neg_ff, neg_in;
   logic [LIGHT_W-1:0]        quo_ff, quo_in;
   logic [DIVISOR_W:0]        rem_ff, rem_in;
   logic [DIVISOR_W-1:0]      divisor_ff, divisor_in;
   logic signed [LIGHT_W-1:0] result_ff, result_in;
   logic [LIGHT_W-1:0]        quo_step;
   logic [DIVISOR_W:0]        rem_step;
   logic [LIGHT_W-1:0]        magnitude;

   assign magnitude = div_req.dividend[LIGHT_W-1] ? LIGHT_W'(-div_req.dividend)
                                                  : LIGHT_W'(div_req.dividend);

   // Restoring long division, DIV_STEP bits per cycle; the remainder stays narrow.
   always_comb begin
      quo_step = quo_ff;
      rem_step = rem_ff;
      for (int k = 0; k < DIV_STEP; k++) begin
         rem_step = {rem_step[DIVISOR_W-1:0], quo_step[LIGHT_W-1]};
         quo_step = {quo_step[LIGHT_W-2:0], 1'b0};
         if (rem_step >= {1'b0, divisor_ff}) begin
            rem_step    = rem_step - {1'b0, divisor_ff};
            quo_step[0] = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      fin_in     = 1'b0;
      done_in    = 1'b0;
      count_in   = count_ff;
      neg_in     = neg_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      result_in  = result_ff;
      if (div_req.go) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(ITER);
         neg_in     = div_req.dividend[LIGHT_W-1];
         quo_in     = magnitude;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quo_in   = quo_step;
         rem_in   = rem_step;
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         result_in = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
         done_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      neg_ff     <= neg_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      result_ff  <= result_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = result_ff;
endmodule

/* rtl/gbbs_back.sv */
// Back stage: box setup sequencing, per-pixel light stepping, shading and result register.
// Depends on gbbs_pkg and the assertion macro header; it reaches the step divider through ports.
`timescale 1ns / 1ps
`include "gouraud_box_band_shading_macros.svh"
module gbbs_back #(
   parameter int BOX_W     = gbbs_pkg::BOX_W_DEF,
   parameter int BOX_H     = gbbs_pkg::BOX_H_DEF,
   parameter int SCREEN_W  = gbbs_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H  = gbbs_pkg::SCREEN_H_DEF,
   parameter int FRAC_BITS = gbbs_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  gbbs_pkg::entry_type   q_entry,
   output gbbs_pkg::div_req_type div_req,
   input  gbbs_pkg::div_rsp_type div_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gbbs_pkg::rsp_type     rsp_word
);
   import gbbs_pkg::*;

   localparam int COL_W = $clog2(BOX_W + 1);
   localparam int ROW_W = $clog2(BOX_H + 1);
   localparam logic signed [POS_W-1:0]   LIMIT_X = POS_W'(SCREEN_W);
   localparam logic signed [POS_W-1:0]   LAST_Y  = POS_W'(SCREEN_H - 1);
   localparam logic signed [LIGHT_W-1:0] TRUNC_BIAS = LIGHT_W'((1 << FRAC_BITS) - 1);

   typedef enum logic [3:0] {
      ST_RUN   = 4'b0001,
      ST_DIV_L = 4'b0010,
      ST_DIV_R = 4'b0100,
      ST_DIV_0 = 4'b1000
   } back_state_type;

   function automatic logic signed [LIGHT_W-1:0] scale(input logic signed [DIFF_W-1:0] v);
      return LIGHT_W'(v) <<< FRAC_BITS;
   endfunction

   back_state_type            state_ff, state_in;
   logic signed [COORD_W-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_W-1:0] origin_y_ff, origin_y_in;
   logic signed [LIGHT_W-1:0] left_light_ff, left_light_in;
   logic signed [LIGHT_W-1:0] left_step_ff, left_step_in;
   logic signed [LIGHT_W-1:0] step_diff_ff, step_diff_in;
   logic signed [LIGHT_W-1:0] run_light_ff, run_light_in;
   logic signed [LIGHT_W-1:0] run_step_ff, run_step_in;
   logic signed [LIGHT_W-1:0] next_step_ff, next_step_in;
   logic signed [LIGHT_W-1:0] ndiff_ff, ndiff_in;
   logic signed [DIFF_W-1:0]  diff_right_ff, diff_right_in;
   logic signed [DIFF_W-1:0]  diff_top_ff, diff_top_in;
   logic                      next_ok_ff, next_ok_in;
   logic [COL_W-1:0]          column_ff, column_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic                      transparent_ff, transparent_in;
   logic                      finished_ff, finished_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_word_ff, rsp_word_in;

   logic                      can_out, last_col, last_row, need_next;
   logic                      pop_start, pop_pixel;
   logic [ROW_W-1:0]          row_inc;
   logic signed [POS_W-1:0]   sx, sy, sy_next;
   logic                      visible, show, past_bottom, start_past_bottom;
   logic signed [LIGHT_W-1:0] biased, light_int, shade_sum, left_next, ndiff_step, ndiff_first;
   logic [SHADE_W-1:0]        shade;

   assign can_out   = ~rsp_valid_ff | ~rsp_stall;
   assign last_col  = (column_ff == COL_W'(BOX_W - 1));
   assign row_inc   = row_ff + 1'b1;
   assign last_row  = (row_inc >= ROW_W'(BOX_H));
   // The last pixel of a row that opens another row needs the next row's step ready.
   assign need_next = ~finished_ff & last_col & ~last_row;
   assign pop_start = (state_ff == ST_RUN) & q_valid & q_entry.is_start;
   assign pop_pixel = (state_ff == ST_RUN) & q_valid & ~q_entry.is_start & can_out
                      & (~need_next | next_ok_ff);
   assign q_pop     = pop_start | pop_pixel;

   assign sx      = POS_W'(origin_x_ff) + $signed(POS_W'(column_ff));
   assign sy      = POS_W'(origin_y_ff) + $signed(POS_W'(row_ff));
   assign sy_next = POS_W'(origin_y_ff) + $signed(POS_W'(row_inc));
   assign visible = ~sy[POS_W-1] & ~sx[POS_W-1] & (sx < LIMIT_X);
   assign show    = visible & ~(transparent_ff & (q_entry.src_pixel == '0));
   assign past_bottom       = (sy_next > LAST_Y);
   assign start_past_bottom = (POS_W'(q_entry.box_y) > LAST_Y);

   // Integer part of the light, truncated toward zero.
   assign biased    = run_light_ff + (run_light_ff[LIGHT_W-1] ? TRUNC_BIAS : '0);
   assign light_int = biased >>> FRAC_BITS;
   assign shade_sum = light_int + $signed(LIGHT_W'(q_entry.src_pixel[SHADE_W-1:0]));

   always_comb begin
      if (shade_sum < 0) begin
         shade = '0;
      end else if (shade_sum > $signed(LIGHT_W'(SHADE_MAX))) begin
         shade = SHADE_MAX;
      end else begin
         shade = shade_sum[SHADE_W-1:0];
      end
   end

   assign left_next   = left_light_ff + left_step_ff;
   assign ndiff_step  = ndiff_ff + step_diff_ff;
   assign ndiff_first = scale(diff_top_ff) + step_diff_ff;

   always_comb begin
      state_in       = state_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      left_light_in  = left_light_ff;
      left_step_in   = left_step_ff;
      step_diff_in   = step_diff_ff;
      run_light_in   = run_light_ff;
      run_step_in    = run_step_ff;
      next_step_in   = next_step_ff;
      ndiff_in       = ndiff_ff;
      diff_right_in  = diff_right_ff;
      diff_top_in    = diff_top_ff;
      next_ok_in     = next_ok_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      transparent_in = transparent_ff;
      finished_in    = finished_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_word_in    = rsp_word_ff;
      div_req.go       = 1'b0;
      div_req.dividend = ndiff_step;
      div_req.divisor  = DIVISOR_W'(BOX_W);
      case (state_ff)
         ST_RUN: begin
            if (div_rsp.done & ~pop_start) begin
               next_step_in = div_rsp.quotient;
               next_ok_in   = 1'b1;
            end
            if (pop_start) begin
               origin_x_in    = q_entry.box_x;
               origin_y_in    = q_entry.box_y;
               left_light_in  = scale(q_entry.light_tl);
               run_light_in   = scale(q_entry.light_tl);
               diff_right_in  = q_entry.diff_right;
               diff_top_in    = q_entry.diff_top;
               transparent_in = q_entry.skip_zero;
               column_in      = '0;
               row_in         = '0;
               finished_in    = start_past_bottom;
               next_ok_in     = 1'b0;
               div_req.go       = 1'b1;
               div_req.dividend = scale(q_entry.diff_left);
               div_req.divisor  = DIVISOR_W'(BOX_H);
               state_in       = ST_DIV_L;
            end else if (pop_pixel & ~finished_ff) begin
               if (show) begin
                  rsp_valid_in         = 1'b1;
                  rsp_word_in.screen_x = sx[OUT_POS_W-1:0];
                  rsp_word_in.screen_y = sy[OUT_POS_W-1:0];
                  rsp_word_in.color    = {q_entry.src_pixel[PIXEL_W-1:SHADE_W], shade};
               end
               run_light_in = run_light_ff + run_step_ff;
               if (last_col) begin
                  column_in     = '0;
                  row_in        = row_inc;
                  left_light_in = left_next;
                  if (last_row) begin
                     finished_in = 1'b1;
                  end else begin
                     run_light_in = left_next;
                     run_step_in  = next_step_ff;
                     finished_in  = past_bottom;
                     // Start on the step of the row after this new one.
                     ndiff_in     = ndiff_step;
                     next_ok_in   = 1'b0;
                     div_req.go   = 1'b1;
                  end
               end else begin
                  column_in = column_ff + 1'b1;
               end
            end
         end
         ST_DIV_L: begin
            if (div_rsp.done) begin
               left_step_in     = div_rsp.quotient;
               div_req.go       = 1'b1;
               div_req.dividend = scale(diff_right_ff);
               div_req.divisor  = DIVISOR_W'(BOX_H);
               state_in         = ST_DIV_R;
            end
         end
         ST_DIV_R: begin
            if (div_rsp.done) begin
               step_diff_in     = div_rsp.quotient - left_step_ff;
               div_req.go       = 1'b1;
               div_req.dividend = scale(diff_top_ff);
               div_req.divisor  = DIVISOR_W'(BOX_W);
               state_in         = ST_DIV_0;
            end
         end
         ST_DIV_0: begin
            if (div_rsp.done) begin
               run_step_in      = div_rsp.quotient;
               ndiff_in         = ndiff_first;
               next_ok_in       = 1'b0;
               div_req.go       = 1'b1;
               div_req.dividend = ndiff_first;
               state_in         = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         next_ok_ff   <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         finished_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ok_ff   <= next_ok_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      origin_x_ff    <= origin_x_in;
      origin_y_ff    <= origin_y_in;
      left_light_ff  <= left_light_in;
      left_step_ff   <= left_step_in;
      step_diff_ff   <= step_diff_in;
      run_light_ff   <= run_light_in;
      run_step_ff    <= run_step_in;
      next_step_ff   <= next_step_in;
      ndiff_ff       <= ndiff_in;
      diff_right_ff  <= diff_right_in;
      diff_top_ff    <= diff_top_in;
      transparent_ff <= transparent_in;
      rsp_word_ff    <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `GBBS_ASSERT(a_no_pop_in_setup, (state_ff != ST_RUN) |-> !q_pop, "word taken during setup")
   `GBBS_ASSERT(a_rsp_from_pixel, $rose(rsp_valid_ff) |-> $past(pop_pixel), "result without pixel")
   `GBBS_ASSERT(a_column_bound, column_ff < COL_W'(BOX_W), "column past box width")
   `GBBS_ASSERT(a_one_step_pending, (div_rsp.done && state_ff == ST_RUN) |-> !next_ok_ff, "step overrun")
endmodule

/* rtl/gouraud_box_band_shading.sv */
// Gouraud box shading with palette bands: top level joining front, queue, divider and back.
// Depends on gbbs_pkg, gbbs_front, gbbs_queue, gbbs_div and gbbs_back.
//
// Use: send a start word (op = start) with the box origin, four corner lights and the
// skip-zero flag, then the BOX_W x BOX_H source pixels in row-major order on the req_
// channel. Each visible, non-transparent pixel gives one rsp_ word with its screen
// position and shaded color; other words give nothing.
// A pixel accepted on the req_ channel passes the front register, a queue entry and the
// result register before its result shows on rsp_valid.
// Throughput: one pixel per cycle inside a box while rsp_stall is low and the next row's
// step is ready. A start word occupies the back stage for three divisions on the shared
// step divider, each an iterative restoring division with a sign fix. Each later row's
// run step is divided during the row before, so a row may wait at its end for the divider.
// Reset clears the queue, the divider and the result register and leaves no box active,
// so pixels before the first start word are dropped.
// When rsp_stall holds, the result register keeps its word; the back stage stops taking
// pixels, the four-word queue fills and then req_stall rises.
`timescale 1ns / 1ps
module gouraud_box_band_shading #(
   parameter int BOX_W     = gbbs_pkg::BOX_W_DEF,
   parameter int BOX_H     = gbbs_pkg::BOX_H_DEF,
   parameter int SCREEN_W  = gbbs_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H  = gbbs_pkg::SCREEN_H_DEF,
   parameter int FRAC_BITS = gbbs_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbbs_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbbs_pkg::rsp_type rsp_word
);
   import gbbs_pkg::*;

   logic        push_valid, push_ready;
   entry_type   push_entry;
   logic        q_valid, q_pop;
   entry_type   q_entry;
   div_req_type div_req;
   div_rsp_type div_rsp;

   gbbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   gbbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_entry)
   );

   gbbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   gbbs_back #(
      .BOX_W     (BOX_W),
      .BOX_H     (BOX_H),
      .SCREEN_W  (SCREEN_W),
      .SCREEN_H  (SCREEN_H),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_entry   (q_entry),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );
endmodule
